// File: design/smr_pkg.sv
package smr_pkg;

  localparam int DATA_W     = 32;
  localparam int DIM_W      = 7;
  localparam int ANGLE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE     = 2'd1;

  // item kinds
  localparam logic MODE_STORE = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef enum logic [ANGLE_W-1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } angle_t;

  // what travels with each queued operation besides address and data
  typedef struct packed {
    logic fetch;
    logic row_end;
    logic matrix_end;
  } op_t;

  localparam int OP_W = $bits(op_t);

endpackage

// File: design/square_matrix_rotator.sv
// channel   direction  handshake              payload
// in        sink       in_valid / in_ready    mode, element_in
// out       source     out_valid / out_ready  element_out, row_end, matrix_end
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one item per cycle unless stalled; the single-port element memory sets that figure
// a fetch result passes the queue, the memory read register and the output register
// reset clears counters, settings, valid flags; data registers, memory stay undefined
// a two-entry queue parts intake from the memory side; out_ready low stalls fetches
// and any item queued behind a stalled fetch
// cfg_ready is always high; in_ready is low while a cfg write is offered
module square_matrix_rotator #(
  parameter int MAX_DIM = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                mode,
  input  logic signed [smr_pkg::DATA_W-1:0]   element_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smr_pkg::DATA_W-1:0]   element_out,
  output logic                                row_end,
  output logic                                matrix_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [smr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int QW = smr_pkg::OP_W + AW + smr_pkg::DATA_W;

  logic                       push_valid;
  logic                       push_ready;
  smr_pkg::op_t               push_op;
  logic [AW-1:0]              push_addr;
  logic [smr_pkg::DATA_W-1:0] push_data;
  logic                       pop_valid;
  logic                       pop_ready;
  logic [QW-1:0]              pop_word;
  smr_pkg::op_t               pop_op;
  logic [AW-1:0]              pop_addr;
  logic [smr_pkg::DATA_W-1:0] pop_data;

  smr_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .element_in (element_in),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .push_addr  (push_addr),
    .push_data  (push_data)
  );

  smr_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_op, push_addr, push_data}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_word)
  );

  assign {pop_op, pop_addr, pop_data} = pop_word;

  smr_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_op      (pop_op),
    .pop_addr    (pop_addr),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .element_out (element_out),
    .row_end     (row_end),
    .matrix_end  (matrix_end)
  );

endmodule

// File: design/smr_front.sv
module smr_front #(
  parameter int MAX_DIM = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  mode,
  input  logic signed [smr_pkg::DATA_W-1:0]     element_in,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [smr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [smr_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                  push_valid,
  input  logic                                  push_ready,
  output smr_pkg::op_t                          push_op,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    push_addr,
  output logic [smr_pkg::DATA_W-1:0]            push_data
);

  localparam int SW = $clog2(MAX_DIM + 1);
  localparam int PW = $clog2(MAX_DIM);
  localparam int AW = $clog2(MAX_DIM * MAX_DIM);
  localparam int CW = (SW > smr_pkg::DIM_W) ? SW : smr_pkg::DIM_W;
  localparam int MW = PW + SW + 1;

  logic [smr_pkg::DIM_W-1:0] dimension;
  smr_pkg::angle_t           angle;
  logic [AW-1:0]             load_position;
  logic [PW-1:0]             out_row;
  logic [PW-1:0]             out_col;
  logic                      loaded;

  logic [SW-1:0]   side;
  logic [PW-1:0]   last;
  logic [2*SW-1:0] area_last;
  logic [PW-1:0]   src_row;
  logic [PW-1:0]   src_col;
  logic [MW-1:0]   src_index;
  logic            take;
  logic            is_store;
  logic            col_last;
  logic            row_last;

  // dimension of zero acts as one, anything above the store acts as the full size
  always_comb begin
    if (dimension == '0) begin
      side = SW'(1);
    end else if (CW'(dimension) > CW'(MAX_DIM)) begin
      side = SW'(MAX_DIM);
    end else begin
      side = SW'(dimension);
    end
  end

  assign last      = PW'(side - SW'(1));
  assign area_last = (2*SW)'(side) * (2*SW)'(side) - (2*SW)'(1);
  assign col_last  = (out_col == last);
  assign row_last  = (out_row == last);

  always_comb begin
    case (angle)
      smr_pkg::ROT_90: begin
        src_row = out_col;
        src_col = last - out_row;
      end
      smr_pkg::ROT_180: begin
        src_row = last - out_row;
        src_col = last - out_col;
      end
      smr_pkg::ROT_270: begin
        src_row = last - out_col;
        src_col = out_row;
      end
      default: begin
        src_row = out_row;
        src_col = out_col;
      end
    endcase
  end

  assign src_index = MW'(src_row) * MW'(side) + MW'(src_col);

  assign cfg_ready = 1'b1;
  // a register write takes the cycle, so no item is taken beside it
  assign in_ready  = push_ready && !cfg_valid;
  assign take      = in_valid && in_ready;
  assign is_store  = (mode == smr_pkg::MODE_STORE);

  // a fetch before the matrix is complete is taken and dropped
  assign push_valid         = take && (is_store || loaded);
  assign push_op.fetch      = !is_store;
  assign push_op.row_end    = col_last;
  assign push_op.matrix_end = col_last && row_last;
  assign push_addr          = is_store ? load_position : src_index[AW-1:0];
  assign push_data          = element_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension     <= smr_pkg::DIM_RESET;
      angle         <= smr_pkg::ROT_0;
      load_position <= '0;
      out_row       <= '0;
      out_col       <= '0;
      loaded        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == smr_pkg::REG_DIMENSION) begin
        dimension     <= cfg_data[smr_pkg::DIM_W-1:0];
        load_position <= '0;
        out_row       <= '0;
        out_col       <= '0;
        loaded        <= 1'b0;
      end else if (cfg_index == smr_pkg::REG_ANGLE) begin
        angle   <= smr_pkg::angle_t'(cfg_data[smr_pkg::ANGLE_W-1:0]);
        out_row <= '0;
        out_col <= '0;
      end
    end else if (take) begin
      if (is_store) begin
        // a store after a full load starts a new matrix
        if (loaded) begin
          out_row <= '0;
          out_col <= '0;
        end
        if ((2*SW)'(load_position) == area_last) begin
          load_position <= '0;
          loaded        <= 1'b1;
        end else begin
          load_position <= load_position + AW'(1);
          loaded        <= 1'b0;
        end
      end else if (loaded) begin
        if (col_last) begin
          out_col <= '0;
          out_row <= row_last ? '0 : out_row + PW'(1);
        end else begin
          out_col <= out_col + PW'(1);
        end
      end
    end
  end

endmodule

// File: design/smr_queue.sv
module smr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/smr_back.sv
module smr_back #(
  parameter int MAX_DIM = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pop_valid,
  output logic                                pop_ready,
  input  smr_pkg::op_t                        pop_op,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  pop_addr,
  input  logic [smr_pkg::DATA_W-1:0]          pop_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smr_pkg::DATA_W-1:0]   element_out,
  output logic                                row_end,
  output logic                                matrix_end
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [smr_pkg::DATA_W-1:0] mem [DEPTH];
  logic [smr_pkg::DATA_W-1:0] rd_data;
  logic                       p_valid;
  logic                       p_row_end;
  logic                       p_matrix_end;
  logic                       p_adv;
  logic                       rd_en;
  logic                       wr_en;

  // read stage moves on when the output register is free or being drained
  assign p_adv     = p_valid && (!out_valid || out_ready);
  assign pop_ready = !pop_op.fetch || !p_valid || p_adv;
  assign rd_en     = pop_valid && pop_ready && pop_op.fetch;
  assign wr_en     = pop_valid && pop_ready && !pop_op.fetch;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pop_addr] <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data      <= mem[pop_addr];
      p_row_end    <= pop_op.row_end;
      p_matrix_end <= pop_op.matrix_end;
    end
    if (p_adv) begin
      element_out <= rd_data;
      row_end     <= p_row_end;
      matrix_end  <= p_matrix_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        p_valid <= 1'b1;
      end else if (p_adv) begin
        p_valid <= 1'b0;
      end
      if (p_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
